FILE: sv/bdclp_pkg.sv
// ----------------------------------------------------------------------------
// bdclp_pkg
// Shared types and constants of the button debounce / click / long press unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bdclp_pkg;

  localparam int unsigned FieldCount = 5;
  localparam int unsigned PinWidth   = 8;
  localparam int unsigned NowWidth   = 32;
  localparam int unsigned LongWidth  = 16;
  localparam int unsigned DebWidth   = 8;
  localparam int unsigned SelWidth   = 3;
  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned InWidth    = 40;  // pins + now, byte aligned
  localparam int unsigned OutWidth   = 16;  // five 2-bit events, byte aligned

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_CLICK = 2'd1,
    EVT_LONG  = 2'd2
  } bdclp_evt_e;

  // register indexes on the write port
  localparam logic [AddrWidth-1:0] REG_LONG_PRESS = 3'd0;
  localparam logic [AddrWidth-1:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [AddrWidth-1:0] REG_UP_BIT     = 3'd2;
  localparam logic [AddrWidth-1:0] REG_DOWN_BIT   = 3'd3;
  localparam logic [AddrWidth-1:0] REG_LEFT_BIT   = 3'd4;
  localparam logic [AddrWidth-1:0] REG_RIGHT_BIT  = 3'd5;
  localparam logic [AddrWidth-1:0] REG_PAIR_BIT   = 3'd6;

  localparam logic [LongWidth-1:0] LongPressReset = 16'd1000;
  localparam logic [DebWidth-1:0]  DebounceReset  = 8'd20;

  // timing settings shared by all lanes
  typedef struct packed {
    logic [LongWidth-1:0] long_press;
    logic [DebWidth-1:0]  debounce;
  } bdclp_timing_t;

endpackage : bdclp_pkg

`default_nettype wire

FILE: sv/button_debounce_click_long_press_unit.sv
// ----------------------------------------------------------------------------
// button_debounce_click_long_press_unit
// Debounced multi-button reader with click and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one request per port capture; tdata carries the 8 active-low
//   pin levels and the millisecond timestamp, tuser the change flag. A request
//   with the flag clear yields all-none events and leaves the state alone.
//   Output stream: one event word per request, 2 bits per button
//   (0 none, 1 click, 2 long press).
//   The event word is registered, in the skid entry if the output stalls. One
//   request per cycle is sustained while the receiver keeps up: each button lane
//   does two subtracts and compares on its own state; all lanes run in parallel.
//   A stalled receiver is covered by an output register plus one skid entry;
//   s_axis_tready drops only once both hold data.
//   Reset (async, active low) clears all button state to released, times to
//   zero and the settings to their defaults (1000 ms long press, 20 ms
//   debounce, buttons on bits 1..5). Settings are written through cfg_we_i
//   while the stream is idle (user's duty, not enforced); unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_click_long_press_unit
  import bdclp_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrWidth-1:0] cfg_addr_i,
  input  wire logic [CfgWidth-1:0]  cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InWidth-1:0]   s_axis_tdata,   // captured_pins[7:0], now_ms[39:8]
  input  wire logic                 s_axis_tuser,   // change_flagged
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutWidth-1:0]       m_axis_tdata    // up, down, left, right, pair
                                                    // (2 bits each), zero pad
);

  localparam int unsigned NumLanes = (NUM_BUTTONS > FieldCount) ? FieldCount : NUM_BUTTONS;

  logic [LongWidth-1:0] long_q;
  logic [DebWidth-1:0]  deb_q;
  logic [SelWidth-1:0]  sel_q [FieldCount];

  bdclp_timing_t         timing;
  logic                  lane_en;
  logic [PinWidth-1:0]   pins;
  logic [NowWidth-1:0]   now32;
  logic [TIME_WIDTH-1:0] now_t;
  logic [OutWidth-1:0]   merged;

  assign timing.long_press = long_q;
  assign timing.debounce   = deb_q;
  assign pins    = s_axis_tdata[PinWidth-1:0];
  assign now32   = s_axis_tdata[PinWidth +: NowWidth];
  assign lane_en = s_axis_tvalid && s_axis_tready && s_axis_tuser;

  if (TIME_WIDTH >= NowWidth) begin : g_now_wide
    assign now_t = TIME_WIDTH'(now32);
  end else begin : g_now_narrow
    assign now_t = now32[TIME_WIDTH-1:0];
  end

  // settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q   <= LongPressReset;
      deb_q    <= DebounceReset;
      sel_q[0] <= 3'd1;
      sel_q[1] <= 3'd2;
      sel_q[2] <= 3'd3;
      sel_q[3] <= 3'd4;
      sel_q[4] <= 3'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LONG_PRESS: long_q   <= cfg_wdata_i[LongWidth-1:0];
        REG_DEBOUNCE:   deb_q    <= cfg_wdata_i[DebWidth-1:0];
        REG_UP_BIT:     sel_q[0] <= cfg_wdata_i[SelWidth-1:0];
        REG_DOWN_BIT:   sel_q[1] <= cfg_wdata_i[SelWidth-1:0];
        REG_LEFT_BIT:   sel_q[2] <= cfg_wdata_i[SelWidth-1:0];
        REG_RIGHT_BIT:  sel_q[3] <= cfg_wdata_i[SelWidth-1:0];
        REG_PAIR_BIT:   sel_q[4] <= cfg_wdata_i[SelWidth-1:0];
        default: ;
      endcase
    end
  end

  // lanes, merged into one event word
  for (genvar i = 0; i < FieldCount; i++) begin : g_lane
    if (i < NumLanes) begin : g_on
      bdclp_evt_e evt;
      bdclp_lane #(
        .TIME_WIDTH(TIME_WIDTH)
      ) u_lane (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (lane_en),
        .pins_i  (pins),
        .sel_i   (sel_q[i]),
        .now_i   (now_t),
        .timing_i(timing),
        .evt_o   (evt)
      );
      assign merged[2*i +: 2] = evt;
    end else begin : g_off
      assign merged[2*i +: 2] = EVT_NONE;
    end
  end
  assign merged[OutWidth-1:2*FieldCount] = '0;

  bdclp_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (merged),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

  // an unflagged request into an empty output shows an all-none word next cycle
  a_unflagged_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid
    |=> m_axis_tdata == '0)
    else $error("unflagged request produced an event");

  // a request taken while the output stalls fills the skid entry
  a_skid_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready
    |=> !s_axis_tready && m_axis_tvalid)
    else $error("skid entry not held after stalled request");

  // no lane reports the unused event code
  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[3:2] != 2'd3) &&
                      (m_axis_tdata[5:4] != 2'd3) && (m_axis_tdata[7:6] != 2'd3) &&
                      (m_axis_tdata[9:8] != 2'd3))
    else $error("invalid event code");

endmodule : button_debounce_click_long_press_unit

`default_nettype wire

FILE: sv/bdclp_lane.sv
// ----------------------------------------------------------------------------
// bdclp_lane
// One button: debounce against last accepted change, click / long press.
// ----------------------------------------------------------------------------
`default_nettype none

module bdclp_lane
  import bdclp_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,       // accepted request with change flag
  input  wire logic [PinWidth-1:0]   pins_i,
  input  wire logic [SelWidth-1:0]   sel_i,
  input  wire logic [TIME_WIDTH-1:0] now_i,
  input  wire bdclp_timing_t         timing_i,
  output bdclp_evt_e                 evt_o
);

  logic                  stable_q, stable_d;
  logic [TIME_WIDTH-1:0] last_q, last_d;
  logic [TIME_WIDTH-1:0] start_q, start_d;

  logic                  pressed;
  logic [TIME_WIDTH-1:0] since_change;
  logic [TIME_WIDTH-1:0] held;
  logic                  take;

  always_comb begin
    pressed      = ~pins_i[sel_i];
    since_change = now_i - last_q;
    held         = now_i - start_q;
    take         = en_i && (pressed != stable_q) &&
                   (since_change >= TIME_WIDTH'(timing_i.debounce));
    stable_d = stable_q;
    last_d   = last_q;
    start_d  = start_q;
    evt_o    = EVT_NONE;
    if (take) begin
      stable_d = pressed;
      last_d   = now_i;
      if (pressed) begin
        start_d = now_i;
      end else begin
        evt_o = (held > TIME_WIDTH'(timing_i.long_press)) ? EVT_LONG : EVT_CLICK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= 1'b0;
      last_q   <= '0;
      start_q  <= '0;
    end else begin
      stable_q <= stable_d;
      last_q   <= last_d;
      start_q  <= start_d;
    end
  end

endmodule : bdclp_lane

`default_nettype wire

FILE: sv/bdclp_skid.sv
// ----------------------------------------------------------------------------
// bdclp_skid
// Output register plus skid stage for the merged event word.
// ----------------------------------------------------------------------------
`default_nettype none

module bdclp_skid
  import bdclp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [OutWidth-1:0] in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [OutWidth-1:0]      out_data_o
);

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  logic [OutWidth-1:0] out_data_q, out_data_d;
  logic [OutWidth-1:0] skid_data_q, skid_data_d;
  logic                push, pop;

  assign in_ready_o  = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    push         = in_valid_i && ~skid_valid_q;
    pop          = out_valid_q && out_ready_i;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_data_d = in_data_i;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_data_d  = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = in_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule : bdclp_skid

`default_nettype wire
